// ----- sv/escape_sequence_classifier_defines.svh -----
// Assertion helpers for the escape sequence classifier.
`ifndef ESCAPE_SEQUENCE_CLASSIFIER_DEFINES_SVH
`define ESCAPE_SEQUENCE_CLASSIFIER_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define ESC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Non-overlapping implication, checked outside reset.
`define ESC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/esc_cls_pkg.sv -----
`default_nettype none

package esc_cls_pkg;

    localparam int OPCODE_W = 2;
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 3;
    localparam int SLOT_W   = 2;
    localparam int SET_W    = 3;
    localparam int LEN_W    = 8;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_START = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_BYTE  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_END   = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NONE  = 2'd3;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_TRUNCATED   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MALFORMED   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SHIFT       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CONTROL     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UNSUPPORTED = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DESIGNATION = 3'd5;

    // character sets
    localparam logic [SET_W-1:0] SET_NULL  = 3'd0;
    localparam logic [SET_W-1:0] SET_PRIM  = 3'd1;
    localparam logic [SET_W-1:0] SET_SUPP  = 3'd2;
    localparam logic [SET_W-1:0] SET_PDI   = 3'd3;
    localparam logic [SET_W-1:0] SET_MOS   = 3'd4;
    localparam logic [SET_W-1:0] SET_MACRO = 3'd5;
    localparam logic [SET_W-1:0] SET_DRCS  = 3'd6;

    // byte values
    localparam logic [BYTE_W-1:0] B_FINAL_LO = 8'h30;
    localparam logic [BYTE_W-1:0] B_FINAL_HI = 8'h7E;
    localparam logic [BYTE_W-1:0] B_C1_LO    = 8'h40;
    localparam logic [BYTE_W-1:0] B_C1_HI    = 8'h5F;
    localparam logic [BYTE_W-1:0] B_LS2      = 8'h6E;
    localparam logic [BYTE_W-1:0] B_LS3      = 8'h6F;
    localparam logic [BYTE_W-1:0] B_CSET_A   = 8'h21;
    localparam logic [BYTE_W-1:0] B_CSET_B   = 8'h22;
    localparam logic [LEN_W-1:0]  LEN_MAX    = 8'd255;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              wide_ok;
    } t_slot_dec;

    typedef struct packed {
        logic [SET_W-1:0] code;
        logic             wide;
    } t_set_dec;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic [SET_W-1:0]  set_code;
        logic [BYTE_W-1:0] c1_code;
        logic [LEN_W-1:0]  seq_length;
        logic              byte_consumed;
    } t_result;

    // slot named by the intermediate byte of a designation
    function automatic t_slot_dec slot_for(input logic [BYTE_W-1:0] im);
        t_slot_dec d;
        d = '{hit: 1'b1, slot: 2'd0, wide_ok: 1'b1};
        unique case (im)
            8'h28: begin
                d.wide_ok = 1'b0;
            end
            8'h29, 8'h2D: d.slot = 2'd1;
            8'h2A, 8'h2E: d.slot = 2'd2;
            8'h2B, 8'h2F: d.slot = 2'd3;
            default: d.hit = 1'b0;
        endcase
        return d;
    endfunction

    // set named by the final byte; 96-position sets flagged wide
    function automatic t_set_dec set_for(input logic [BYTE_W-1:0] fb);
        t_set_dec d;
        d = '{code: SET_NULL, wide: 1'b0};
        unique case (fb)
            8'h42: d.code = SET_PRIM;
            8'h7C: d.code = SET_SUPP;
            8'h57: d = '{code: SET_PDI,   wide: 1'b1};
            8'h7D: d = '{code: SET_MOS,   wide: 1'b1};
            8'h7A: d = '{code: SET_MACRO, wide: 1'b1};
            8'h7B: d = '{code: SET_DRCS,  wide: 1'b1};
            default: d.code = SET_NULL;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- sv/esc_cls_ifs.sv -----
`default_nettype none

interface esc_cls_in_if;
    logic                             valid;
    logic                             ready;
    logic [esc_cls_pkg::OPCODE_W-1:0] opcode;
    logic [esc_cls_pkg::BYTE_W-1:0]   byte_value;

    modport source (output valid, opcode, byte_value, input ready);
    modport sink   (input valid, opcode, byte_value, output ready);
endinterface

interface esc_cls_out_if;
    logic                           valid;
    logic                           ready;
    logic [esc_cls_pkg::KIND_W-1:0] kind;
    logic [esc_cls_pkg::SLOT_W-1:0] slot;
    logic [esc_cls_pkg::SET_W-1:0]  set_code;
    logic [esc_cls_pkg::BYTE_W-1:0] c1_code;
    logic [esc_cls_pkg::LEN_W-1:0]  seq_length;
    logic                           byte_consumed;

    modport source (output valid, kind, slot, set_code, c1_code, seq_length,
                    byte_consumed, input ready);
    modport sink   (input valid, kind, slot, set_code, c1_code, seq_length,
                    byte_consumed, output ready);
endinterface

`default_nettype wire

// ----- sv/escape_sequence_classifier.sv -----
// Channel   Dir  Payload                                        Handshake
// i_item    in   opcode[1:0], byte_value[7:0]                   valid/ready
// o_result  out  kind, slot, set_code, c1_code, seq_length,     valid/ready
//                byte_consumed
//
// One item per cycle sustained unless a held result stalls the input stage; an item loads
// the input register at its transfer, and its result, if it closes a sequence, loads the
// result register when stage 1 moves on.
// i_rst_n is synchronous, active low: closes any open sequence, empties both
// stages.
// A held result stalls the input stage only when that stage also has an item;
// i_item.ready is low only while both stages are full and o_result.ready low.
`default_nettype none

`include "escape_sequence_classifier_defines.svh"

module escape_sequence_classifier (
    input  wire           i_clk,
    input  wire           i_rst_n,
    esc_cls_in_if.sink    i_item,
    esc_cls_out_if.source o_result
);

    localparam int B = esc_cls_pkg::BYTE_W;

    // input stage
    logic                             r_s1_valid;
    logic [esc_cls_pkg::OPCODE_W-1:0] r_s1_op;
    logic [B-1:0]                     r_s1_byte;

    // sequence state
    logic                             r_in_seq,   n_in_seq;
    logic [B-1:0]                     r_im_count, n_im_count;
    logic [B-1:0]                     r_first_im, n_first_im;

    // result register
    logic                             r_out_valid;
    esc_cls_pkg::t_result             r_out,      n_out;

    logic                             s1_go;
    logic                             emit;
    logic [esc_cls_pkg::LEN_W:0]      sum0, sum1;
    logic [esc_cls_pkg::LEN_W-1:0]    len0, len1;
    logic                             is_inter, is_fin_byte, is_c1;
    esc_cls_pkg::t_slot_dec           sd;
    esc_cls_pkg::t_set_dec            fd;

    // stage 1 moves on when the result register is free or being drained
    assign s1_go        = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_s1_valid || s1_go;

    // length with and without the final byte, saturating
    assign sum0 = {1'b0, r_im_count} + 9'd1;
    assign sum1 = {1'b0, r_im_count} + 9'd2;
    assign len0 = sum0[esc_cls_pkg::LEN_W] ? esc_cls_pkg::LEN_MAX : sum0[esc_cls_pkg::LEN_W-1:0];
    assign len1 = sum1[esc_cls_pkg::LEN_W] ? esc_cls_pkg::LEN_MAX : sum1[esc_cls_pkg::LEN_W-1:0];

    assign is_inter    = (r_s1_byte[7:4] == 4'h2);
    assign is_fin_byte = (r_s1_byte >= esc_cls_pkg::B_FINAL_LO) &&
                         (r_s1_byte <= esc_cls_pkg::B_FINAL_HI);
    assign is_c1       = (r_s1_byte >= esc_cls_pkg::B_C1_LO) &&
                         (r_s1_byte <= esc_cls_pkg::B_C1_HI);
    assign sd          = esc_cls_pkg::slot_for(r_first_im);
    assign fd          = esc_cls_pkg::set_for(r_s1_byte);

    always_comb begin
        n_in_seq   = r_in_seq;
        n_im_count = r_im_count;
        n_first_im = r_first_im;
        emit       = 1'b0;
        n_out      = '{kind: esc_cls_pkg::KIND_TRUNCATED, slot: '0,
                       set_code: esc_cls_pkg::SET_NULL, c1_code: '0,
                       seq_length: len0, byte_consumed: 1'b1};

        unique case (r_s1_op)
            esc_cls_pkg::OP_START: begin
                // also abandons any open sequence silently
                n_in_seq   = 1'b1;
                n_im_count = '0;
                n_first_im = '0;
            end
            esc_cls_pkg::OP_END: begin
                if (r_in_seq) begin
                    emit     = 1'b1;
                    n_in_seq = 1'b0;
                end
            end
            esc_cls_pkg::OP_BYTE: begin
                if (r_in_seq) begin
                    if (is_inter) begin
                        if (r_im_count == '0)
                            n_first_im = r_s1_byte;
                        if (r_im_count != esc_cls_pkg::LEN_MAX)
                            n_im_count = r_im_count + 8'd1;
                    end else begin
                        emit     = 1'b1;
                        n_in_seq = 1'b0;
                        if (!is_fin_byte) begin
                            // terminator is left for the caller to execute
                            n_out.kind          = esc_cls_pkg::KIND_MALFORMED;
                            n_out.byte_consumed = 1'b0;
                        end else begin
                            n_out.seq_length = len1;
                            if (r_im_count == '0) begin
                                if (r_s1_byte == esc_cls_pkg::B_LS2) begin
                                    n_out.kind = esc_cls_pkg::KIND_SHIFT;
                                    n_out.slot = 2'd2;
                                end else if (r_s1_byte == esc_cls_pkg::B_LS3) begin
                                    n_out.kind = esc_cls_pkg::KIND_SHIFT;
                                    n_out.slot = 2'd3;
                                end else if (is_c1) begin
                                    n_out.kind    = esc_cls_pkg::KIND_CONTROL;
                                    n_out.c1_code = r_s1_byte;
                                end else begin
                                    n_out.kind = esc_cls_pkg::KIND_UNSUPPORTED;
                                end
                            end else if (r_im_count != 8'd1 ||
                                         r_first_im == esc_cls_pkg::B_CSET_A ||
                                         r_first_im == esc_cls_pkg::B_CSET_B ||
                                         !sd.hit) begin
                                n_out.kind = esc_cls_pkg::KIND_UNSUPPORTED;
                            end else begin
                                // 96-position sets cannot go into G0
                                n_out.kind     = esc_cls_pkg::KIND_DESIGNATION;
                                n_out.slot     = sd.slot;
                                n_out.set_code = (fd.wide && !sd.wide_ok) ?
                                                 esc_cls_pkg::SET_NULL : fd.code;
                            end
                        end
                    end
                end
            end
            esc_cls_pkg::OP_NONE: begin
                emit = 1'b0;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_in_seq    <= 1'b0;
            r_im_count  <= '0;
            r_first_im  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready)
                r_s1_valid <= i_item.valid;
            if (s1_go) begin
                r_in_seq    <= n_in_seq;
                r_im_count  <= n_im_count;
                r_first_im  <= n_first_im;
                r_out_valid <= emit;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_s1_op   <= i_item.opcode;
            r_s1_byte <= i_item.byte_value;
        end
        if (s1_go && emit)
            r_out <= n_out;
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.kind          = r_out.kind;
    assign o_result.slot          = r_out.slot;
    assign o_result.set_code      = r_out.set_code;
    assign o_result.c1_code       = r_out.c1_code;
    assign o_result.seq_length    = r_out.seq_length;
    assign o_result.byte_consumed = r_out.byte_consumed;

    // a result only comes out of an open sequence
    `ESC_ASSERT_IMPL(a_result_from_open, i_clk, i_rst_n, $rose(r_out_valid),
        $past(r_in_seq), "result without open sequence")
    // a sequence closes only on a processed byte or end of data
    `ESC_ASSERT_IMPL(a_close_cause, i_clk, i_rst_n, $fell(r_in_seq),
        $past(s1_go) && ($past(r_s1_op) == esc_cls_pkg::OP_BYTE ||
        $past(r_s1_op) == esc_cls_pkg::OP_END), "sequence closed without cause")
    // a C1 control is always ESC plus one final byte
    `ESC_ASSERT_IMPL(a_control_len, i_clk, i_rst_n,
        r_out_valid && r_out.kind == esc_cls_pkg::KIND_CONTROL,
        r_out.seq_length == 8'd2, "control with wrong length")
    // G0 never receives a 96-position set
    `ESC_ASSERT_IMPL(a_g0_narrow, i_clk, i_rst_n,
        r_out_valid && r_out.kind == esc_cls_pkg::KIND_DESIGNATION && r_out.slot == 2'd0,
        r_out.set_code == esc_cls_pkg::SET_NULL || r_out.set_code == esc_cls_pkg::SET_PRIM ||
        r_out.set_code == esc_cls_pkg::SET_SUPP, "wide set in G0")
    // an emitted item lands in the result register
    `ESC_ASSERT_NEXT(a_emit_lands, i_clk, i_rst_n, s1_go && emit, r_out_valid,
        "result lost")

endmodule

`default_nettype wire
